[hdl/hsec_pkg.sv]
// Shared types, widths, status codes and elaboration-time helpers for the
// Hamming single-error corrector. No dependencies.
package hsec_pkg;

  localparam int CODE_W           = 63;
  localparam int DATA_W           = 57;
  localparam int LEN_W            = 6;
  localparam int STAT_W           = 2;
  localparam int APB_ADDR_W       = 3;
  localparam int APB_DATA_W       = 32;
  localparam int MAX_CODE_LEN_DEF = 63;

  localparam logic [LEN_W-1:0] MIN_CODE_LEN = 6'd3;
  localparam logic [LEN_W-1:0] LEN_RESET    = 6'd7;

  // Register index, taken from the word address.
  localparam logic REG_CODE_LENGTH = 1'b0;

  localparam logic [STAT_W-1:0] STAT_CLEAN     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_CORRECTED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BEYOND    = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0] data_word;
    logic [LEN_W-1:0]  data_length;
    logic [LEN_W-1:0]  error_position;
    logic [STAT_W-1:0] status;
  } res_t;

  function automatic logic is_pow2(input int p);
    return (p != 0) && ((p & (p - 1)) == 0);
  endfunction

  // Positions that contribute to syndrome bit j.
  function automatic logic [CODE_W-1:0] syn_mask(input int j);
    logic [CODE_W-1:0] m;
    m = '0;
    for (int p = 1; p <= CODE_W; p++) begin
      m[p-1] = ((p >> j) & 1) != 0;
    end
    return m;
  endfunction

  // 1-based codeword position of the k-th data bit.
  function automatic int data_pos(input int k);
    int cnt;
    int pos;
    cnt = 0;
    pos = 0;
    for (int p = 1; p <= CODE_W; p++) begin
      if (!is_pow2(p)) begin
        if (cnt == k) pos = p;
        cnt = cnt + 1;
      end
    end
    return pos;
  endfunction

endpackage

[hdl/hsec_cfg.sv]
// APB-style register block holding the code length.
// Depends on hsec_pkg.
module hsec_cfg
  import hsec_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [LEN_W-1:0]      code_length
);

  logic reg_sel;

  assign reg_sel = (paddr[APB_ADDR_W-1] == REG_CODE_LENGTH);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_length <= LEN_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      code_length <= pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata[LEN_W-1:0] = code_length;
    end
  end

endmodule

[hdl/hsec_decode.sv]
// Combinational decode pass: length clamp, syndrome XOR trees, single-bit
// correction and data bit compaction. Depends on hsec_pkg.
module hsec_decode
  import hsec_pkg::*;
#(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  logic [MAX_CODE_LEN-1:0] word,
  input  logic [LEN_W-1:0]        code_length,
  output res_t                    res
);

  localparam logic [LEN_W-1:0] MaxN = LEN_W'(MAX_CODE_LEN);

  logic [LEN_W-1:0]        n;
  logic [LEN_W-1:0]        r;
  logic [LEN_W-1:0]        syn;
  logic [MAX_CODE_LEN-1:0] masked;
  logic [MAX_CODE_LEN-1:0] fixed;
  logic [DATA_W-1:0]       data;
  logic                    in_range;

  always_comb begin
    if (code_length < MIN_CODE_LEN) begin
      n = MIN_CODE_LEN;
    end else if (code_length > MaxN) begin
      n = MaxN;
    end else begin
      n = code_length;
    end
  end

  always_comb begin
    if (n <= 6'd3) begin
      r = 6'd2;
    end else if (n <= 6'd7) begin
      r = 6'd3;
    end else if (n <= 6'd15) begin
      r = 6'd4;
    end else if (n <= 6'd31) begin
      r = 6'd5;
    end else begin
      r = 6'd6;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_CODE_LEN; i++) begin
      masked[i] = word[i] & (LEN_W'(i) < n);
    end
  end

  for (genvar j = 0; j < LEN_W; j++) begin : g_syn
    localparam logic [CODE_W-1:0] Mask = syn_mask(j);
    assign syn[j] = ^(masked & Mask[MAX_CODE_LEN-1:0]);
  end

  // A syndrome past the used length names no bit, so nothing is flipped.
  assign in_range = (syn != '0) && (syn <= n);

  always_comb begin
    for (int i = 0; i < MAX_CODE_LEN; i++) begin
      fixed[i] = masked[i] ^ (in_range && (syn == LEN_W'(i + 1)));
    end
  end

  for (genvar k = 0; k < DATA_W; k++) begin : g_data
    localparam int Pos = data_pos(k);
    if (Pos <= MAX_CODE_LEN) begin : g_bit
      assign data[k] = fixed[Pos-1];
    end else begin : g_zero
      assign data[k] = 1'b0;
    end
  end

  always_comb begin
    res.data_word      = data;
    res.data_length    = n - r;
    res.error_position = syn;
    if (syn == '0) begin
      res.status = STAT_CLEAN;
    end else if (in_range) begin
      res.status = STAT_CORRECTED;
    end else begin
      res.status = STAT_BEYOND;
    end
  end

endmodule

[hdl/hamming_single_error_corrector.sv]
// Top level of the Hamming single-error corrector: input register, decode
// pass and result register. Depends on hsec_pkg, hsec_cfg and hsec_decode.
//
// Takes one received codeword per cycle while in_ready is high and returns
// one result per word. A word accepted into the input register is decoded
// by a single pass of XOR trees and per-bit compares, and lands in the
// result register, raising out_valid, once that register is empty or being
// emptied. Throughput is one word per cycle for as long as out_ready stays
// high; a stalled result holds the result register, and in_ready falls only
// when both registers hold a word and out_ready is low.
// code_length is written over the APB-style port at byte address 0 and may
// be changed only while no word is in flight.
module hamming_single_error_corrector
  import hsec_pkg::*;
#(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CODE_W-1:0]     codeword,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_W-1:0]     data_word,
  output logic [LEN_W-1:0]      data_length,
  output logic [LEN_W-1:0]      error_position,
  output logic [STAT_W-1:0]     status
);

  logic [LEN_W-1:0]        code_length;
  logic                    s1_valid;
  logic [MAX_CODE_LEN-1:0] s1_word;
  logic                    out_take;
  logic                    s1_take;
  res_t                    dec_res;
  res_t                    res;

  hsec_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .code_length (code_length)
  );

  hsec_decode #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_decode (
    .word        (s1_word),
    .code_length (code_length),
    .res         (dec_res)
  );

  // The result register can load when it is empty or being emptied.
  assign out_take = !out_valid || out_ready;
  assign s1_take  = !s1_valid || out_take;
  assign in_ready = s1_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_take) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && in_valid) begin
      s1_word <= codeword[MAX_CODE_LEN-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && s1_valid) begin
      res <= dec_res;
    end
  end

  assign data_word      = res.data_word;
  assign data_length    = res.data_length;
  assign error_position = res.error_position;
  assign status         = res.status;

endmodule

[hdl/hsec_checker.sv]
// Port-level checks for the Hamming single-error corrector, bound to the
// top level. Depends on hsec_pkg and hamming_single_error_corrector.
module hsec_checker
  import hsec_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] data_word,
  input logic [LEN_W-1:0]  data_length,
  input logic [LEN_W-1:0]  error_position,
  input logic [STAT_W-1:0] status
);

  a_reset_empty : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid straight after reset");

  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_word)
      && $stable(error_position) && $stable(status))
    else $error("stalled result word changed");

  a_clean_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_CLEAN) |-> error_position == '0)
    else $error("clean word with non-zero syndrome");

  a_corr_nonzero : assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_CORRECTED) |-> error_position != '0)
    else $error("corrected word with zero syndrome");

  // The syndrome exceeds the used length, which itself exceeds the data length.
  a_beyond_len : assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_BEYOND) |-> error_position > data_length)
    else $error("uncorrectable word with syndrome inside the length");

endmodule

bind hamming_single_error_corrector hsec_checker u_hsec_checker (.*);

[dv/hsec_decode_checker.sv]
// Decode checker for the Hamming single-error corrector: watches the APB port and both
// word channels, predicts each decode and compares the results. Depends on hsec_pkg.
`timescale 1ns / 1ps
module hsec_decode_checker
  import hsec_pkg::*;
#(
  parameter int MAX_LEN = MAX_CODE_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic [APB_DATA_W-1:0] prdata,
  input  logic                  pready,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [CODE_W-1:0]     codeword,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [DATA_W-1:0]     data_word,
  input  logic [LEN_W-1:0]      data_length,
  input  logic [LEN_W-1:0]      error_position,
  input  logic [STAT_W-1:0]     status,
  output int unsigned           outstanding,
  output int unsigned           fail_count
);

  res_t             pending_decodes[$];
  logic [LEN_W-1:0] len_reg;
  int unsigned      errs = 0;

  function automatic res_t predict_decode(logic [CODE_W-1:0] cw, logic [LEN_W-1:0] reg_len);
    int               n;
    int               r;
    int               k;
    logic [63:0]      mask;
    logic [LEN_W-1:0] syn;
    logic [CODE_W-1:0] w;
    res_t             res;
    n = (reg_len < MIN_CODE_LEN) ? int'(MIN_CODE_LEN) : int'(reg_len);
    if (n > MAX_LEN) n = MAX_LEN;
    mask = (64'd1 << n) - 64'd1;
    w = cw & mask[CODE_W-1:0];
    r = 2;
    while (n > (1 << r) - 1) r++;
    syn = '0;
    for (int p = 1; p <= n; p++) begin
      if (w[p-1]) syn = syn ^ LEN_W'(p);
    end
    res = '0;
    if (syn == '0) begin
      res.status = STAT_CLEAN;
    end else if (int'(syn) <= n) begin
      w[syn-1] = ~w[syn-1];
      res.status = STAT_CORRECTED;
    end else begin
      // The syndrome points past the end of the word, so nothing is flipped.
      res.status = STAT_BEYOND;
    end
    k = 0;
    for (int p = 1; p <= n; p++) begin
      if ((p & (p - 1)) != 0) begin
        res.data_word[k] = w[p-1];
        k++;
      end
    end
    res.data_length    = LEN_W'(n - r);
    res.error_position = syn;
    return res;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin : track
    res_t want;
    if (rst) begin
      len_reg = LEN_RESET;
      pending_decodes.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_decodes.size() == 0) begin
          $error("result word arrived with no decode pending");
          errs++;
        end else begin
          want = pending_decodes.pop_front();
          check_field("data_word", want.data_word, data_word);
          check_field("data_length", want.data_length, data_length);
          check_field("error_position", want.error_position, error_position);
          check_field("status", want.status, status);
        end
      end
      if (in_valid && in_ready) pending_decodes.push_back(predict_decode(codeword, len_reg));
      if (psel && penable && pready && paddr[APB_ADDR_W-1:2] == REG_CODE_LENGTH) begin
        if (pwrite) begin
          len_reg = pwdata[LEN_W-1:0];
        end else begin
          check_field("code_length", len_reg, prdata[LEN_W-1:0]);
        end
      end
    end
    outstanding <= pending_decodes.size();
    fail_count  <= errs;
  end

endmodule

[dv/tb_hamming_single_error_corrector.sv]
// Hamming single-error corrector testbench top: clock, reset, APB programming and codeword
// stimulus with random gaps and stalls. Depends on hsec_pkg, hsec_decode_checker and the DUT.
`timescale 1ns / 1ps
module tb_hamming_single_error_corrector;
  import hsec_pkg::*;

  localparam int LIMIT        = 800_000;
  localparam int RANDOM_WORDS = 1950;
  localparam int PHASES       = 10;

  localparam logic [APB_ADDR_W-1:0] LEN_ADDR      = {REG_CODE_LENGTH, 2'b00};
  localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR = {~REG_CODE_LENGTH, 2'b00};

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [APB_ADDR_W-1:0] paddr     = '0;
  logic [APB_DATA_W-1:0] pwdata    = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [CODE_W-1:0]     codeword  = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [DATA_W-1:0]     data_word;
  logic [LEN_W-1:0]      data_length;
  logic [LEN_W-1:0]      error_position;
  logic [STAT_W-1:0]     status;

  int unsigned outstanding;
  int unsigned fail_count;
  int unsigned cycles     = 0;
  int          ready_hold = 0;
  bit          no_idle    = 1'b0;
  int          n_eff      = 7;

  hamming_single_error_corrector uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .codeword(codeword),
    .out_valid(out_valid), .out_ready(out_ready),
    .data_word(data_word), .data_length(data_length),
    .error_position(error_position), .status(status)
  );

  hsec_decode_checker checker_i (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .codeword(codeword),
    .out_valid(out_valid), .out_ready(out_ready),
    .data_word(data_word), .data_length(data_length),
    .error_position(error_position), .status(status),
    .outstanding(outstanding), .fail_count(fail_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("hamming_single_error_corrector regression: fail");
      $finish;
    end
  end

  // Result-side back-pressure: mostly short bursts either way, now and then a long stall.
  always @(posedge clk) begin : ready_gen
    int pick;
    if (no_idle) begin
      out_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        out_ready  <= 1'b1;
        ready_hold <= $urandom_range(0, 15);
      end else if (pick < 92) begin
        out_ready  <= 1'b0;
        ready_hold <= $urandom_range(0, 2);
      end else begin
        out_ready  <= 1'b0;
        ready_hold <= $urandom_range(10, 40);
      end
    end
  end

  function automatic logic [CODE_W-1:0] rand_bits();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[CODE_W-1:0];
  endfunction

  function automatic int next_gap();
    int pick;
    if (no_idle) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  // Builds a clean codeword: data in the non-power-of-two positions, then each parity
  // position set so that it cancels its bit of the syndrome.
  function automatic logic [CODE_W-1:0] encode(logic [DATA_W-1:0] data, int n);
    logic [CODE_W-1:0] w;
    logic [LEN_W-1:0]  syn;
    int                k;
    w = '0;
    syn = '0;
    k = 0;
    for (int p = 1; p <= n; p++) begin
      if ((p & (p - 1)) != 0) begin
        w[p-1] = data[k];
        if (data[k]) syn = syn ^ LEN_W'(p);
        k++;
      end
    end
    for (int j = 0; j < LEN_W; j++) begin
      if (syn[j]) w[(1 << j) - 1] = 1'b1;
    end
    return w;
  endfunction

  function automatic logic [CODE_W-1:0] bit_at(int pos);
    return CODE_W'(1) << (pos - 1);
  endfunction

  // Mostly valid words, clean or with one flipped bit; the rest double errors or noise.
  function automatic logic [CODE_W-1:0] make_word(int n);
    logic [CODE_W-1:0] cw;
    int                pick;
    int                p1;
    int                p2;
    pick = $urandom_range(0, 99);
    cw = encode(DATA_W'(rand_bits()), n);
    if (pick < 35) begin
    end else if (pick < 70) begin
      cw = cw ^ bit_at($urandom_range(1, n));
    end else if (pick < 82) begin
      p1 = $urandom_range(1, n);
      p2 = $urandom_range(1, n - 1);
      if (p2 >= p1) p2++;
      cw = cw ^ bit_at(p1) ^ bit_at(p2);
    end else begin
      cw = rand_bits();
    end
    if (n < CODE_W && $urandom_range(0, 3) == 0) cw = cw ^ (rand_bits() << n);
    return cw;
  endfunction

  task automatic send_word(logic [CODE_W-1:0] cw);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    codeword <= cw;
    do @(posedge clk); while (!in_ready);
  endtask

  // Leaves psel high so that a second access can follow straight on.
  task automatic apb_access(logic wr, logic [APB_ADDR_W-1:0] addr,
                            logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  // Writes a register once the pipeline has drained, then reads code_length back.
  task automatic write_reg(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    apb_access(1'b1, addr, value);
    apb_access(1'b0, LEN_ADDR, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == LEN_ADDR) begin
      n_eff = (value[LEN_W-1:0] < MIN_CODE_LEN) ? int'(MIN_CODE_LEN) : int'(value[LEN_W-1:0]);
    end
  endtask

  initial begin : stimulus
    logic [LEN_W-1:0]      len;
    logic [APB_DATA_W-1:0] junk;
    logic [CODE_W-1:0]     clean;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_access(1'b0, LEN_ADDR, '0);
    psel    <= 1'b0;
    penable <= 1'b0;

    // Reset length of seven, including ignored bits above the word.
    clean = encode(DATA_W'(rand_bits()), 7);
    send_word('0);
    send_word({CODE_W{1'b1}});
    send_word(clean);
    send_word(clean ^ bit_at(1));
    send_word(clean ^ bit_at(7));
    send_word(clean | {{(CODE_W-7){1'b1}}, 7'b0});

    // A length of zero acts as the minimum of three.
    write_reg(LEN_ADDR, 32'd0);
    send_word('0);
    send_word({CODE_W{1'b1}});
    send_word(CODE_W'(3'b100));
    send_word(CODE_W'(3'b001));

    // Length five: syndromes six and seven point past the end.
    write_reg(LEN_ADDR, 32'd5);
    send_word(CODE_W'(5'b01010));
    send_word(CODE_W'(5'b01011));

    // Longest word, with junk in the upper bits of the write data.
    write_reg(LEN_ADDR, {26'h3FFFFFF, 6'd63});
    clean = encode(DATA_W'(rand_bits()), 63);
    send_word({CODE_W{1'b1}});
    send_word('0);
    send_word(clean);
    send_word(clean ^ bit_at(63));
    send_word(clean ^ bit_at(32));
    send_word(clean ^ bit_at(1));

    // A write to an unmapped address must leave the length alone.
    write_reg(UNMAPPED_ADDR, 32'd3);
    send_word(encode(DATA_W'(rand_bits()), 63) ^ bit_at(41));

    // Sixty-four wraps to zero in six bits; one and two also act as three.
    write_reg(LEN_ADDR, 32'd64);
    send_word({CODE_W{1'b1}} ^ bit_at(2));
    write_reg(LEN_ADDR, 32'd1);
    send_word(rand_bits());
    write_reg(LEN_ADDR, 32'd2);
    send_word(rand_bits());

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0, 7:    len = 6'd63;
        1:       len = 6'd3;
        2:       len = 6'd7;
        3:       len = 6'd15;
        4:       len = 6'd16;
        5:       len = 6'd31;
        6:       len = 6'd32;
        default: len = LEN_W'($urandom_range(0, 63));
      endcase
      junk = $urandom;
      write_reg(LEN_ADDR, (ph % 2 == 1) ? {junk[APB_DATA_W-1:LEN_W], len} : APB_DATA_W'(len));
      no_idle <= (ph == 3);
      for (int i = 0; i < RANDOM_WORDS / PHASES; i++) send_word(make_word(n_eff));
      no_idle <= 1'b0;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("hamming_single_error_corrector regression: pass");
    end else begin
      $display("hamming_single_error_corrector regression: fail");
    end
    $finish;
  end

endmodule
